>>> rtl/sol_pkg.sv
// Shared types, constants and codes for the self-organizing list.
package sol_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_BITS = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int LEN_W    = 8;
    localparam int PADDR_W  = 3;

    localparam logic [PADDR_W-3:0] REG_HEURISTIC = '0;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic HEUR_MTF       = 1'b0;
    localparam logic HEUR_TRANSPOSE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_UP_RD,
        S_UP_WR,
        S_KEY_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          mode;
        logic [KEY_BITS-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [LEN_W-1:0] length;
    } t_result;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [KEY_BITS-1:0] wdata;
        logic [ADDR_W-1:0]   raddr;
    } t_mem_req;

endpackage

>>> rtl/sol_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module sol_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sol_ctrl.sv
// Sequencer that searches and shifts the list entries held in the RAM.
module sol_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  sol_pkg::t_cmd                i_cmd,
    input  logic                         i_heur,
    input  logic [sol_pkg::KEY_BITS-1:0] i_rdata,
    output sol_pkg::t_mem_req            o_mem,
    output logic                         busy,
    output logic                         o_done,
    output sol_pkg::t_result             o_result
);

    import sol_pkg::*;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [1:0]          r_status, n_status;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [1:0]          r_mode, n_mode;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                last;

    assign last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_status <= ST_OK;
            r_mode   <= MODE_INSERT;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_status <= n_status;
            r_mode   <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_status = r_status;
        n_occ    = r_occ;
        n_mode   = r_mode;
        n_key    = r_key;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_cmd.mode;
                    n_key    = i_cmd.key;
                    n_pos    = '0;
                    n_status = ST_OK;
                    n_idx    = '0;
                    unique case (i_cmd.mode)
                        MODE_INSERT: begin
                            if (r_occ == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_occ == '0) begin
                                n_state = S_KEY_WR;
                            end else begin
                                n_idx   = ADDR_W'(r_occ - CNT_W'(1));
                                n_state = S_UP_RD;
                            end
                        end
                        MODE_DELETE, MODE_FIND: begin
                            if (r_occ == '0) begin
                                n_status = ST_MISSING;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SRCH_RD;
                            end
                        end
                        default: begin
                            n_status = ST_MISSING;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_rdata == r_key) begin
                    n_pos = r_idx;
                    if (r_mode == MODE_DELETE) begin
                        if (last) begin
                            n_occ   = r_occ - CNT_W'(1);
                            n_state = S_DONE;
                        end else begin
                            n_idx   = r_idx + ADDR_W'(1);
                            n_state = S_DN_RD;
                        end
                    end else if (r_idx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx - ADDR_W'(1);
                        n_state = S_UP_RD;
                    end
                end else if (last) begin
                    n_status = ST_MISSING;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_UP_RD: begin
                n_state = S_UP_WR;
            end
            S_UP_WR: begin
                if (r_idx == '0 || (r_mode == MODE_FIND && i_heur == HEUR_TRANSPOSE)) begin
                    n_state = S_KEY_WR;
                end else begin
                    n_idx   = r_idx - ADDR_W'(1);
                    n_state = S_UP_RD;
                end
            end
            S_KEY_WR: begin
                if (r_mode == MODE_INSERT) begin
                    n_occ = r_occ + CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_DN_RD: begin
                n_state = S_DN_WR;
            end
            S_DN_WR: begin
                if (last) begin
                    n_occ   = r_occ - CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_DN_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.waddr = r_idx;
        o_mem.wdata = r_key;
        o_mem.raddr = r_idx;
        unique case (r_state)
            S_UP_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx + ADDR_W'(1);
                o_mem.wdata = i_rdata;
            end
            S_KEY_WR: begin
                o_mem.we = 1'b1;
            end
            S_DN_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx - ADDR_W'(1);
                o_mem.wdata = i_rdata;
            end
            default: begin
                o_mem.we = 1'b0;
            end
        endcase
        busy            = (r_state != S_IDLE);
        o_done          = (r_state == S_DONE);
        o_result.status   = r_status;
        o_result.position = POS_W'(r_pos);
        o_result.length   = LEN_W'(r_occ);
    end

endmodule

>>> rtl/self_organizing_list.sv
// Top level of the self-organizing list: register port, sequencer and entry RAM.
//
// A command beat (mode and key on i_cmd) is taken at a clock edge where start
// is high and busy is low. Mode insert puts the key at the front, delete
// removes the first matching key, and find looks the key up and then moves it
// to the front or swaps it with its predecessor, as the heuristic register
// selects. Every command yields one result beat: o_done is high for exactly
// one cycle with status, the matched position and the new length on o_result.
// The receiver cannot stall, so the result must be taken in that cycle.
// The keys live in a RAM with one write and one registered read port; each
// entry that is searched takes a read and a compare step, and each entry that
// is shifted takes a read and a write step. A delete or find on an empty list
// and an insert on a full list go straight to the result beat.
// Reset empties the list and selects move-to-front; no clearing pass runs.
// The heuristic register is written through the APB port; the user must write
// it only while busy is low, as the block itself does not enforce this.
module self_organizing_list (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sol_pkg::t_cmd               i_cmd,
    output logic                        o_done,
    output sol_pkg::t_result            o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sol_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import sol_pkg::*;

    logic                r_heur;
    logic                cfg_hit;
    t_mem_req            mem_req;
    logic [KEY_BITS-1:0] rdata;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_HEURISTIC);
    assign prdata  = cfg_hit ? {31'b0, r_heur} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heur <= HEUR_MTF;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_heur <= pwdata[0];
        end
    end

    sol_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start && !busy),
        .i_cmd    (i_cmd),
        .i_heur   (r_heur),
        .i_rdata  (rdata),
        .o_mem    (mem_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    sol_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted command did not raise busy.");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("Result beat did not return the block to idle.");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_result.length) <= 32'(CAPACITY)))
        else $error("Reported length exceeds capacity.");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (32'(o_result.length) == 32'(CAPACITY)))
        else $error("Full status reported on a list that is not full.");

endmodule
